>>> rtl/assert_macros.svh
// Assertion helpers shared by the cache modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication or plain property, checked on every rising edge out of reset.
`define SLC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("cache check failed");

// A condition that must hold in the cycle after a trigger.
`define SLC_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("cache check failed");

`endif

>>> rtl/slc_pkg.sv
package slc_pkg;

  // Input word kinds.
  typedef enum logic [1:0] {
    K_READ   = 2'd0,
    K_WRITE  = 2'd1,
    K_PROBE  = 2'd2,
    K_REFILL = 2'd3
  } kind_e;

  // Result word kinds.
  typedef enum logic [2:0] {
    RK_READ  = 3'd0,
    RK_WRITE = 3'd1,
    RK_PROBE = 3'd2,
    RK_FETCH = 3'd3,
    RK_MEMW  = 3'd4,
    RK_WB    = 3'd5
  } rkind_e;

  // Controller states, one-hot.
  typedef enum logic [14:0] {
    ST_IDLE     = 15'b000000000000001,
    ST_LOOK     = 15'b000000000000010,
    ST_HIT_RD   = 15'b000000000000100,
    ST_HIT_OUT  = 15'b000000000001000,
    ST_WT_MEM   = 15'b000000000010000,
    ST_WT_DONE  = 15'b000000000100000,
    ST_VICT     = 15'b000000001000000,
    ST_WB_RD    = 15'b000000010000000,
    ST_WB_OUT   = 15'b000000100000000,
    ST_FETCH    = 15'b000001000000000,
    ST_PR_RD    = 15'b000010000000000,
    ST_PR_OUT   = 15'b000100000000000,
    ST_PR_MISS  = 15'b001000000000000,
    ST_FILL_RD  = 15'b010000000000000,
    ST_FILL_OUT = 15'b100000000000000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic   accept;
    logic   refill;
    logic   look_hit;
    logic   look_miss;
    logic   stamp;
    logic   cnt_access;
    logic   cnt_miss;
    logic   cnt_evict;
    logic   vict_init;
    logic   vict_step;
    logic   wi_clear;
    logic   wi_inc;
    logic   rd;
    logic   rd_word;
    logic   merge;
    logic   mark_dirty;
    logic   set_pend;
    logic   emit;
    logic   last;
    rkind_e rkind;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_e kind;
    logic  pend_valid;
    logic  pend_write;
    logic  wb_mode;
    logic  hit;
    logic  any_invalid;
    logic  vict_done;
    logic  vict_dirty;
    logic  wi_last;
    logic  rf_last;
    logic  out_space;
  } status_t;

endpackage

>>> rtl/slc_ctrl.sv
`include "assert_macros.svh"

module slc_ctrl import slc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t sts_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rkind = RK_READ;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        unique case (sts_i.kind)
          K_REFILL: begin
            if (!sts_i.pend_valid) begin
              state_d = ST_IDLE;
            end else begin
              cmd_o.refill = 1'b1;
              state_d = sts_i.rf_last ? ST_FILL_RD : ST_IDLE;
            end
          end
          K_PROBE: begin
            if (sts_i.hit) begin
              cmd_o.look_hit = 1'b1;
              cmd_o.wi_clear = 1'b1;
              state_d = ST_PR_RD;
            end else begin
              cmd_o.look_miss = 1'b1;
              state_d = ST_PR_MISS;
            end
          end
          default: begin
            if (sts_i.pend_valid) begin
              state_d = ST_IDLE;
            end else begin
              cmd_o.cnt_access = 1'b1;
              if (sts_i.hit) begin
                cmd_o.look_hit = 1'b1;
                state_d = ST_HIT_RD;
              end else if (sts_i.kind == K_WRITE && !sts_i.wb_mode) begin
                cmd_o.cnt_miss  = 1'b1;
                cmd_o.look_miss = 1'b1;
                state_d = ST_WT_MEM;
              end else begin
                cmd_o.cnt_miss  = 1'b1;
                cmd_o.vict_init = 1'b1;
                state_d = sts_i.any_invalid ? ST_FETCH : ST_VICT;
              end
            end
          end
        endcase
      end
      ST_HIT_RD: begin
        cmd_o.stamp = 1'b1;
        cmd_o.rd    = 1'b1;
        if (sts_i.kind == K_WRITE && !sts_i.wb_mode) begin
          state_d = ST_WT_MEM;
        end else begin
          state_d = ST_HIT_OUT;
        end
      end
      ST_HIT_OUT: begin
        if (sts_i.out_space) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = 1'b1;
          if (sts_i.kind == K_WRITE) begin
            cmd_o.rkind      = RK_WRITE;
            cmd_o.merge      = 1'b1;
            cmd_o.mark_dirty = 1'b1;
          end else begin
            cmd_o.rkind = RK_READ;
          end
          state_d = ST_IDLE;
        end
      end
      ST_WT_MEM: begin
        if (sts_i.out_space) begin
          cmd_o.emit  = 1'b1;
          cmd_o.rkind = RK_MEMW;
          cmd_o.merge = sts_i.hit;
          state_d = ST_WT_DONE;
        end
      end
      ST_WT_DONE: begin
        if (sts_i.out_space) begin
          cmd_o.emit  = 1'b1;
          cmd_o.last  = 1'b1;
          cmd_o.rkind = RK_WRITE;
          state_d = ST_IDLE;
        end
      end
      ST_VICT: begin
        if (!sts_i.vict_done) begin
          cmd_o.vict_step = 1'b1;
        end else if (sts_i.vict_dirty) begin
          cmd_o.cnt_evict = 1'b1;
          cmd_o.wi_clear  = 1'b1;
          state_d = ST_WB_RD;
        end else begin
          state_d = ST_FETCH;
        end
      end
      ST_WB_RD: begin
        cmd_o.rd      = 1'b1;
        cmd_o.rd_word = 1'b1;
        state_d = ST_WB_OUT;
      end
      ST_WB_OUT: begin
        if (sts_i.out_space) begin
          cmd_o.emit   = 1'b1;
          cmd_o.rkind  = RK_WB;
          cmd_o.wi_inc = 1'b1;
          state_d = sts_i.wi_last ? ST_FETCH : ST_WB_RD;
        end
      end
      ST_FETCH: begin
        if (sts_i.out_space) begin
          cmd_o.emit     = 1'b1;
          cmd_o.last     = 1'b1;
          cmd_o.rkind    = RK_FETCH;
          cmd_o.set_pend = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_PR_RD: begin
        cmd_o.rd      = 1'b1;
        cmd_o.rd_word = 1'b1;
        state_d = ST_PR_OUT;
      end
      ST_PR_OUT: begin
        if (sts_i.out_space) begin
          cmd_o.emit   = 1'b1;
          cmd_o.rkind  = RK_PROBE;
          cmd_o.last   = sts_i.wi_last;
          cmd_o.wi_inc = 1'b1;
          state_d = sts_i.wi_last ? ST_IDLE : ST_PR_RD;
        end
      end
      ST_PR_MISS: begin
        if (sts_i.out_space) begin
          cmd_o.emit  = 1'b1;
          cmd_o.last  = 1'b1;
          cmd_o.rkind = RK_PROBE;
          state_d = ST_IDLE;
        end
      end
      ST_FILL_RD: begin
        cmd_o.rd = 1'b1;
        state_d = ST_FILL_OUT;
      end
      ST_FILL_OUT: begin
        if (sts_i.out_space) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = 1'b1;
          if (sts_i.pend_write) begin
            cmd_o.rkind      = RK_WRITE;
            cmd_o.merge      = 1'b1;
            cmd_o.mark_dirty = 1'b1;
          end else begin
            cmd_o.rkind = RK_READ;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A word is only handed over when the output register can take it.
  `SLC_ASSERT(a_emit_space, clk_i, rst_ni, cmd_o.emit |-> sts_i.out_space)

endmodule

>>> rtl/slc_dp.sv
`include "assert_macros.svh"

module slc_dp import slc_pkg::*; #(
  parameter int NUM_SETS    = 64,
  parameter int NUM_WAYS    = 4,
  parameter int BLOCK_WORDS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wb_mode_i,
  input  logic [1:0]  kind_i,
  input  logic [31:0] address_i,
  input  logic [31:0] word_data_i,
  input  logic [31:0] bit_mask_i,
  input  cmd_t        cmd_i,
  output status_t     sts_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_kind_o,
  output logic [31:0] out_data_o,
  output logic [31:0] mem_address_o,
  output logic [31:0] mem_mask_o,
  output logic        hit_o,
  output logic        dirty_o,
  output logic [1:0]  way_index_o,
  output logic        last_o,
  output logic [31:0] access_total_o,
  output logic [31:0] miss_total_o,
  output logic [31:0] dirty_evict_total_o
);

  localparam int OB   = $clog2(BLOCK_WORDS);
  localparam int SB   = $clog2(NUM_SETS);
  localparam int WB   = $clog2(NUM_WAYS);
  localparam int OIW  = (OB > 0) ? OB : 1;
  localparam int SIW  = (SB > 0) ? SB : 1;
  localparam int WIW  = (WB > 0) ? WB : 1;
  localparam int TW   = 30 - OB - SB;
  localparam int LW   = SIW + WIW;
  localparam int DW   = LW + OIW;
  localparam int ROWS = 2 ** SIW;

  typedef logic [NUM_WAYS-1:0][TW-1:0] tag_row_t;
  typedef logic [NUM_WAYS-1:0][31:0]   age_row_t;

  // Field extraction from a byte address.
  function automatic logic [SIW-1:0] set_of(input logic [31:0] a);
    return SIW'((a >> (2 + OB)) & 32'(NUM_SETS - 1));
  endfunction

  function automatic logic [TW-1:0] tag_of(input logic [31:0] a);
    return TW'(a >> (2 + OB + SB));
  endfunction

  function automatic logic [OIW-1:0] off_of(input logic [31:0] a);
    return OIW'((a >> 2) & 32'(BLOCK_WORDS - 1));
  endfunction

  function automatic logic [31:0] blk_addr(input logic [TW-1:0] t, input logic [SIW-1:0] s,
                                           input logic [OIW-1:0] o);
    return (32'(t) << (2 + OB + SB)) | ((32'(s) & 32'(NUM_SETS - 1)) << (2 + OB)) |
           ((32'(o) & 32'(BLOCK_WORDS - 1)) << 2);
  endfunction

  // Storage.
  tag_row_t    tag_mem [ROWS];
  age_row_t    age_mem [ROWS];
  logic [31:0] cnt_mem [ROWS];
  logic [31:0] data_mem [2 ** DW];

  logic [2**LW-1:0] valid_q, dirty_q;
  logic [ROWS-1:0]  cnt_vld_q;

  // Current word context.
  kind_e          ctx_kind_q;
  logic [31:0]    ctx_addr_q, ctx_data_q, ctx_mask_q, rf_data_q;
  logic [SIW-1:0] ctx_set;
  logic [TW-1:0]  ctx_tag;
  logic [OIW-1:0] ctx_off;
  logic [WIW-1:0] cur_way_q;
  logic           hit_q;
  logic [WIW:0]   vidx_q;
  logic [OIW-1:0] wi_q, rcnt_q;

  tag_row_t    tag_row_q;
  age_row_t    age_row_q;
  logic [31:0] cnt_rd_q, rdata_q;

  // Outstanding miss.
  logic           pend_valid_q, pend_write_q;
  logic [31:0]    pend_addr_q, pend_data_q, pend_mask_q;
  logic [WIW-1:0] pend_way_q;

  logic [31:0] acc_q, miss_q, evict_q;

  // Output register.
  logic        out_valid_q, out_hit_q, out_dirty_q, out_last_q;
  logic [2:0]  out_kind_q;
  logic [1:0]  out_way_q;
  logic [31:0] out_data_q, out_addr_q, out_mask_q, out_acc_q, out_miss_q, out_evict_q;

  assign ctx_set = set_of(ctx_addr_q);
  assign ctx_tag = tag_of(ctx_addr_q);
  assign ctx_off = off_of(ctx_addr_q);

  // Lookup over the ways of the current set.
  logic           hit_c, any_inv_c;
  logic [WIW-1:0] hit_way_c, inv_way_c;

  always_comb begin
    hit_c     = 1'b0;
    any_inv_c = 1'b0;
    hit_way_c = '0;
    inv_way_c = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (valid_q[{ctx_set, WIW'(w)}] && tag_row_q[w] == ctx_tag) begin
        hit_c     = 1'b1;
        hit_way_c = WIW'(w);
      end
      if (!valid_q[{ctx_set, WIW'(w)}]) begin
        any_inv_c = 1'b1;
        inv_way_c = WIW'(w);
      end
    end
  end

  logic [LW-1:0] cur_line;
  logic          commit;
  logic          wi_last, rf_last;
  logic          out_space;

  assign cur_line  = {ctx_set, cur_way_q};
  assign wi_last   = (wi_q == OIW'(BLOCK_WORDS - 1));
  assign rf_last   = (rcnt_q == OIW'(BLOCK_WORDS - 1));
  assign commit    = cmd_i.refill && rf_last;
  assign out_space = !out_valid_q || out_ready_i;

  // Status to the controller.
  always_comb begin
    sts_o.kind        = ctx_kind_q;
    sts_o.pend_valid  = pend_valid_q;
    sts_o.pend_write  = pend_write_q;
    sts_o.wb_mode     = wb_mode_i;
    sts_o.hit         = hit_c;
    sts_o.any_invalid = any_inv_c;
    sts_o.vict_done   = (vidx_q == (WIW + 1)'(NUM_WAYS));
    sts_o.vict_dirty  = dirty_q[cur_line];
    sts_o.wi_last     = wi_last;
    sts_o.rf_last     = rf_last;
    sts_o.out_space   = out_space;
  end

  // Row reads at acceptance; a refill looks at the pending set.
  logic [SIW-1:0] rd_set;
  assign rd_set = (kind_e'(kind_i) == K_REFILL) ? set_of(pend_addr_q) : set_of(address_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      tag_row_q <= tag_mem[rd_set];
      age_row_q <= age_mem[rd_set];
      cnt_rd_q  <= cnt_mem[rd_set];
    end
  end

  // Age stamp: bump the set counter and give the new value to the current way.
  logic [31:0] cnt_new;
  age_row_t    age_row_new;
  tag_row_t    tag_row_new;

  always_comb begin
    cnt_new = (cnt_vld_q[ctx_set] ? cnt_rd_q : 32'd0) + 32'd1;
    age_row_new = age_row_q;
    age_row_new[cur_way_q] = cnt_new;
    tag_row_new = tag_row_q;
    tag_row_new[cur_way_q] = ctx_tag;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.stamp || commit) begin
      age_mem[ctx_set] <= age_row_new;
      cnt_mem[ctx_set] <= cnt_new;
    end
    if (commit) begin
      tag_mem[ctx_set] <= tag_row_new;
    end
  end

  // Data store: one write and one registered read per cycle.
  logic [31:0]   merged;
  logic [DW-1:0] rd_idx;

  assign merged = (ctx_data_q & ctx_mask_q) | (rdata_q & ~ctx_mask_q);
  assign rd_idx = {cur_line, cmd_i.rd_word ? wi_q : ctx_off};

  always_ff @(posedge clk_i) begin
    if (cmd_i.refill) begin
      data_mem[{cur_line, rcnt_q}] <= rf_data_q;
    end else if (cmd_i.merge) begin
      data_mem[{cur_line, ctx_off}] <= merged;
    end
    if (cmd_i.rd) begin
      rdata_q <= data_mem[rd_idx];
    end
  end

  // Context and scratch registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ctx_kind_q <= kind_e'(kind_i);
      rf_data_q  <= word_data_i;
      if (kind_e'(kind_i) == K_REFILL) begin
        ctx_addr_q <= pend_addr_q;
        ctx_data_q <= pend_data_q;
        ctx_mask_q <= pend_mask_q;
      end else begin
        ctx_addr_q <= address_i;
        ctx_data_q <= word_data_i;
        ctx_mask_q <= bit_mask_i;
      end
    end
    if (cmd_i.set_pend) begin
      pend_addr_q  <= ctx_addr_q;
      pend_data_q  <= ctx_data_q;
      pend_mask_q  <= ctx_mask_q;
      pend_way_q   <= cur_way_q;
      pend_write_q <= (ctx_kind_q == K_WRITE);
    end
  end

  // Way selection and the victim search, one way per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_way_q <= '0;
      hit_q     <= 1'b0;
      vidx_q    <= '0;
      wi_q      <= '0;
    end else begin
      if (cmd_i.accept && kind_e'(kind_i) == K_REFILL) begin
        cur_way_q <= pend_way_q;
      end
      if (commit) begin
        hit_q <= 1'b0;
      end
      if (cmd_i.look_hit) begin
        cur_way_q <= hit_way_c;
        hit_q     <= 1'b1;
      end
      if (cmd_i.look_miss) begin
        cur_way_q <= '0;
        hit_q     <= 1'b0;
      end
      if (cmd_i.vict_init) begin
        cur_way_q <= any_inv_c ? inv_way_c : '0;
        hit_q     <= 1'b0;
        vidx_q    <= (WIW + 1)'(1);
      end
      if (cmd_i.vict_step) begin
        if (age_row_q[vidx_q[WIW-1:0]] < age_row_q[cur_way_q]) begin
          cur_way_q <= vidx_q[WIW-1:0];
        end
        vidx_q <= vidx_q + (WIW + 1)'(1);
      end
      if (cmd_i.wi_clear) begin
        wi_q <= '0;
      end else if (cmd_i.wi_inc) begin
        wi_q <= wi_q + OIW'(1);
      end
    end
  end

  // Line flags, set counter flags, pending miss and refill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      dirty_q      <= '0;
      cnt_vld_q    <= '0;
      pend_valid_q <= 1'b0;
      rcnt_q       <= '0;
    end else begin
      if (cmd_i.stamp || commit) begin
        cnt_vld_q[ctx_set] <= 1'b1;
      end
      if (cmd_i.refill) begin
        rcnt_q <= rf_last ? '0 : rcnt_q + OIW'(1);
      end
      if (commit) begin
        valid_q[cur_line] <= 1'b1;
        dirty_q[cur_line] <= 1'b0;
        pend_valid_q      <= 1'b0;
      end
      if (cmd_i.merge && cmd_i.mark_dirty) begin
        dirty_q[cur_line] <= 1'b1;
      end
      if (cmd_i.set_pend) begin
        valid_q[cur_line] <= 1'b0;
        dirty_q[cur_line] <= 1'b0;
        pend_valid_q      <= 1'b1;
        rcnt_q            <= '0;
      end
    end
  end

  // Saturating event counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      miss_q  <= '0;
      evict_q <= '0;
    end else begin
      if (cmd_i.cnt_access && acc_q != '1) begin
        acc_q <= acc_q + 32'd1;
      end
      if (cmd_i.cnt_miss && miss_q != '1) begin
        miss_q <= miss_q + 32'd1;
      end
      if (cmd_i.cnt_evict && evict_q != '1) begin
        evict_q <= evict_q + 32'd1;
      end
    end
  end

  // Result word fields by kind.
  logic [31:0] way_ext;
  logic [31:0] f_data, f_addr, f_mask;
  logic        f_hit, f_dirty;
  logic [1:0]  f_way;

  assign way_ext = 32'(cur_way_q);

  always_comb begin
    f_data  = '0;
    f_addr  = '0;
    f_mask  = '0;
    f_hit   = hit_q;
    f_dirty = 1'b0;
    f_way   = way_ext[1:0];
    unique case (cmd_i.rkind)
      RK_READ: begin
        f_data = rdata_q;
      end
      RK_WRITE: begin
      end
      RK_PROBE: begin
        if (hit_q) begin
          f_data  = rdata_q;
          f_addr  = blk_addr(ctx_tag, ctx_set, wi_q);
          f_dirty = dirty_q[cur_line];
        end else begin
          f_way = '0;
        end
      end
      RK_FETCH: begin
        f_addr = blk_addr(ctx_tag, ctx_set, '0);
      end
      RK_MEMW: begin
        f_data = ctx_data_q;
        f_addr = ctx_addr_q;
        f_mask = ctx_mask_q;
      end
      RK_WB: begin
        f_data = rdata_q;
        f_addr = blk_addr(tag_row_q[cur_way_q], ctx_set, wi_q);
      end
      default: begin
        f_hit = 1'b0;
        f_way = '0;
      end
    endcase
  end

  // Output register: holds a word until the consumer takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_q  <= cmd_i.rkind;
      out_data_q  <= f_data;
      out_addr_q  <= f_addr;
      out_mask_q  <= f_mask;
      out_hit_q   <= f_hit;
      out_dirty_q <= f_dirty;
      out_way_q   <= f_way;
      out_last_q  <= cmd_i.last;
      out_acc_q   <= acc_q;
      out_miss_q  <= miss_q;
      out_evict_q <= evict_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign result_kind_o       = out_kind_q;
  assign out_data_o          = out_data_q;
  assign mem_address_o       = out_addr_q;
  assign mem_mask_o          = out_mask_q;
  assign hit_o               = out_hit_q;
  assign dirty_o             = out_dirty_q;
  assign way_index_o         = out_way_q;
  assign last_o              = out_last_q;
  assign access_total_o      = out_acc_q;
  assign miss_total_o        = out_miss_q;
  assign dirty_evict_total_o = out_evict_q;

  // A refill in progress implies an outstanding miss.
  `SLC_ASSERT(a_rcnt_pend, clk_i, rst_ni, (rcnt_q != '0) |-> pend_valid_q)
  // The access count only ever steps by one.
  `SLC_ASSERT(a_acc_step, clk_i, rst_ni, (acc_q != $past(acc_q)) |-> (acc_q == $past(acc_q) + 32'd1))
  // Sending the fetch request opens the outstanding miss.
  `SLC_ASSERT_NEXT(a_fetch_pend, clk_i, rst_ni, cmd_i.emit && cmd_i.set_pend, pend_valid_q)

endmodule

>>> rtl/set_assoc_lru_cache_top.sv
// A read hit or a write-back write hit passes through lookup, data read and output.
// A write-through write sends its memory word after lookup, plus a data read on a hit.
// A miss runs a victim search if no way is invalid and then reads and outputs each dirty
// victim word in turn. One word is taken at a time, and a new one only while idle.
// A probe hit reads and outputs each block word in turn; refill words enter one by one.
// Reset: all lines invalid, no miss outstanding, counters zero, write-back mode on.
module set_assoc_lru_cache_top import slc_pkg::*; #(
  parameter int NUM_SETS    = 64,
  parameter int NUM_WAYS    = 4,
  parameter int BLOCK_WORDS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] address_i,
  input  logic [31:0] word_data_i,
  input  logic [31:0] bit_mask_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_kind_o,
  output logic [31:0] out_data_o,
  output logic [31:0] mem_address_o,
  output logic [31:0] mem_mask_o,
  output logic        hit_o,
  output logic        dirty_o,
  output logic [1:0]  way_index_o,
  output logic        last_o,
  output logic [31:0] access_total_o,
  output logic [31:0] miss_total_o,
  output logic [31:0] dirty_evict_total_o
);

  logic    wb_mode_q;
  cmd_t    cmd;
  status_t sts;

  // Configuration register: write-back mode, decoded where paddr bit 2 is zero.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, wb_mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_mode_q <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      wb_mode_q <= pwdata[0];
    end
  end

  slc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  slc_dp #(
    .NUM_SETS    (NUM_SETS),
    .NUM_WAYS    (NUM_WAYS),
    .BLOCK_WORDS (BLOCK_WORDS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .wb_mode_i           (wb_mode_q),
    .kind_i              (kind_i),
    .address_i           (address_i),
    .word_data_i         (word_data_i),
    .bit_mask_i          (bit_mask_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .result_kind_o       (result_kind_o),
    .out_data_o          (out_data_o),
    .mem_address_o       (mem_address_o),
    .mem_mask_o          (mem_mask_o),
    .hit_o               (hit_o),
    .dirty_o             (dirty_o),
    .way_index_o         (way_index_o),
    .last_o              (last_o),
    .access_total_o      (access_total_o),
    .miss_total_o        (miss_total_o),
    .dirty_evict_total_o (dirty_evict_total_o)
  );

endmodule
